@@ design/sfa_pkg.sv @@
// Shared types and constants of the segregated free-list allocator.
package sfa_pkg;

   localparam int ADDR_W = 17;
   localparam logic [ADDR_W-1:0] NIL_LINK = 17'h1FFFF;

   localparam int SZ_W    = 12;  // rounded object size in bytes
   localparam int CNT_W   = 7;   // objects per refill
   localparam int TOTAL_W = 19;  // size times count
   localparam int GET_W   = 21;  // bytes taken from the backing store
   localparam int DIV_W   = 19;  // shifted divisor in the carve count division

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
   localparam logic [1:0] ST_TOO_LARGE = 2'd2;
   localparam logic [1:0] ST_NO_MEMORY = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] CSR_ALIGN_SHIFT = 2'd0;
   localparam logic [1:0] CSR_MAX_SIZE    = 2'd1;
   localparam logic [1:0] CSR_PER_REFILL  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_POP,
      S_MUL,
      S_LEFT,
      S_GROW,
      S_SEARCH,
      S_CHECK,
      S_DIV,
      S_SPAN,
      S_SETUP,
      S_LINK,
      S_DONE
   } sfa_state_type;

endpackage

@@ design/segregated_freelist_allocator.sv @@
// Segregated free-list pool allocator: top level with link memory and sequencer.
//
// Serves one allocate or free request at a time over a byte arena. A size rounds
// up to the alignment max(2^align_shift, MIN_ALIGN_BYTES); each size class keeps a
// free list whose head sits in a flip-flop array and whose next links sit in a
// one-port synchronous link memory (one read or one write per cycle, with a
// registered read). An allocation from a non-empty list pops the head, reading its
// next link from the link memory. A refill multiplies size by objects_per_refill,
// takes a new region when the old one is too small, divides for the carve count
// when the region holds fewer than objects_per_refill objects, and then writes one
// link per carved object after the first, one per cycle through the link memory.
// When the backing store is exhausted it walks the larger classes instead and
// pops a borrowed object to serve as the new region.
// The link-write loop of the refill sets the long-run rate.
// A finished response sits in an output register, so the next request is taken
// while the previous response still waits. Configuration must be written only
// while idle; the block itself does not enforce this. The link memory needs no
// clearing pass since every link is written before it is read.
module segregated_freelist_allocator #(
   parameter int ARENA_BYTES     = 65536,
   parameter int NUM_CLASSES     = 16,
   parameter int MIN_ALIGN_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_size_bytes,
   input  logic [15:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_address,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_write_data
);
   import sfa_pkg::*;

   localparam int LINK_DEPTH = ARENA_BYTES / MIN_ALIGN_BYTES;
   localparam int IDX_W      = $clog2(LINK_DEPTH);
   localparam int MIN_SHIFT  = $clog2(MIN_ALIGN_BYTES);
   localparam int HI_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CLS_W      = $clog2(NUM_CLASSES + 1);

   // configuration
   logic [2:0]  align_shift_ff;
   logic [10:0] max_size_ff;
   logic [6:0]  per_refill_ff;

   // sequencer and request
   sfa_state_type state_ff, state_in;
   logic        op_ff, op_in;
   logic [15:0] size_ff, size_in;
   logic [15:0] addr_ff, addr_in;
   logic [HI_W-1:0] cls_ff, cls_in;
   logic [HI_W-1:0] tgt_ff, tgt_in;
   logic [CLS_W-1:0] search_ff, search_in;
   logic        hit_ff, hit_in;
   logic [SZ_W-1:0] sz_ff, sz_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [GET_W-1:0] get_ff, get_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] q_ff, q_in;
   logic [2:0]  step_ff, step_in;
   logic [ADDR_W-1:0] rem_ff, rem_in;
   logic [ADDR_W-1:0] first_ff, first_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic [15:0] res_addr_ff, res_addr_in;
   logic [1:0]  res_status_ff, res_status_in;

   // allocator state
   logic [ADDR_W-1:0] region_start_ff, region_start_in;
   logic [ADDR_W-1:0] region_end_ff, region_end_in;
   logic [ADDR_W-1:0] heap_ff, heap_in;
   logic [ADDR_W-1:0] backing_ff, backing_in;
   logic [ADDR_W-1:0] head_ff [NUM_CLASSES];

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // head array and link memory ports
   logic              hd_we;
   logic [HI_W-1:0]   hd_idx;
   logic [ADDR_W-1:0] hd_val;
   logic [ADDR_W-1:0] link_mem [LINK_DEPTH];
   logic              mem_we, mem_re;
   logic [IDX_W-1:0]  mem_widx, mem_ridx;
   logic [ADDR_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] rd_data_ff;

   // derived values
   logic [2:0]        shift;
   logic [7:0]        align_m1;
   logic [ADDR_W-1:0] rounded;
   logic [ADDR_W-1:0] residue;
   logic [ADDR_W-1:0] left_q;
   logic [ADDR_W-1:0] heap_round;
   logic [ADDR_W-1:0] class_bytes;
   logic [21:0]       grow_end;
   logic [DIV_W-1:0]  divisor;
   logic [TOTAL_W-1:0] setup_sum;
   logic [CNT_W-1:0]  n_eff;

   function automatic logic [IDX_W-1:0] link_idx(input logic [ADDR_W-1:0] a);
      return a[MIN_SHIFT +: IDX_W];
   endfunction

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

   always_comb begin
      shift    = (align_shift_ff < 3'(MIN_SHIFT)) ? 3'(MIN_SHIFT) : align_shift_ff;
      align_m1 = 8'((9'd1 << shift) - 9'd1);
      rounded  = (17'(size_ff) + 17'(align_m1)) >> shift;
      residue  = (region_end_ff >= region_start_ff) ? region_end_ff - region_start_ff
                                                    : '0;
      left_q   = residue >> shift;
      heap_round = ((17'(heap_ff >> 4) + 17'(align_m1)) >> shift) << shift;
      grow_end = 22'(backing_ff) + 22'(get_ff);
      divisor  = DIV_W'(sz_ff) << step_ff;
      setup_sum = TOTAL_W'(region_start_ff) + total_ff;
      n_eff    = (per_refill_ff == '0) ? CNT_W'(1) : per_refill_ff;
      if (state_ff == S_POP) begin
         class_bytes = 17'(17'(tgt_ff) + 17'd1) << shift;
      end else begin
         class_bytes = 17'(17'(search_ff) + 17'd1) << shift;
      end
   end

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      size_in         = size_ff;
      addr_in         = addr_ff;
      cls_in          = cls_ff;
      tgt_in          = tgt_ff;
      search_in       = search_ff;
      hit_in          = hit_ff;
      sz_in           = sz_ff;
      total_in        = total_ff;
      get_in          = get_ff;
      n_in            = n_ff;
      q_in            = q_ff;
      step_in         = step_ff;
      rem_in          = rem_ff;
      first_in        = first_ff;
      cursor_in       = cursor_ff;
      res_addr_in     = res_addr_ff;
      res_status_in   = res_status_ff;
      region_start_in = region_start_ff;
      region_end_in   = region_end_ff;
      heap_in         = heap_ff;
      backing_in      = backing_ff;
      rsp_addr_in     = rsp_addr_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      hd_we     = 1'b0;
      hd_idx    = cls_ff;
      hd_val    = '0;
      mem_we    = 1'b0;
      mem_widx  = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_ridx  = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               size_in  = req_size_bytes;
               addr_in  = req_address;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cls_in      = HI_W'(rounded - 17'd1);
            res_addr_in = '0;
            if (size_ff == '0) begin
               res_status_in = ST_ZERO_SIZE;
               state_in      = S_DONE;
            end else if (size_ff > 16'(max_size_ff) || rounded > 17'(NUM_CLASSES)) begin
               res_status_in = ST_TOO_LARGE;
               state_in      = S_DONE;
            end else if (op_ff == OP_FREE) begin
               // push the released object onto its class
               hd_we         = 1'b1;
               hd_idx        = HI_W'(rounded - 17'd1);
               hd_val        = 17'(addr_ff);
               mem_we        = 1'b1;
               mem_widx      = link_idx(17'(addr_ff));
               mem_wdata     = head_ff[HI_W'(rounded - 17'd1)];
               res_status_in = ST_OK;
               state_in      = S_DONE;
            end else if (head_ff[HI_W'(rounded - 17'd1)] != NIL_LINK) begin
               tgt_in   = HI_W'(rounded - 17'd1);
               hit_in   = 1'b1;
               first_in = head_ff[HI_W'(rounded - 17'd1)];
               mem_re   = 1'b1;
               mem_ridx = link_idx(head_ff[HI_W'(rounded - 17'd1)]);
               state_in = S_POP;
            end else begin
               sz_in    = SZ_W'(rounded << shift);
               state_in = S_MUL;
            end
         end
         S_POP: begin
            hd_we  = 1'b1;
            hd_idx = tgt_ff;
            hd_val = rd_data_ff;
            if (hit_ff) begin
               res_addr_in   = first_ff[15:0];
               res_status_in = ST_OK;
               state_in      = S_DONE;
            end else begin
               // the borrowed object becomes the new region
               region_start_in = first_ff;
               region_end_in   = first_ff + class_bytes;
               state_in        = S_CHECK;
            end
         end
         S_MUL: begin
            total_in = TOTAL_W'(sz_ff) * TOTAL_W'(n_eff);
            n_in     = n_eff;
            state_in = (residue < 17'(sz_ff)) ? S_LEFT : S_CHECK;
         end
         S_LEFT: begin
            // hand the leftover to the list of its own size, then drop the region
            if (left_q != '0 && left_q <= 17'(NUM_CLASSES)) begin
               hd_we     = 1'b1;
               hd_idx    = HI_W'(left_q - 17'd1);
               hd_val    = region_start_ff;
               mem_we    = 1'b1;
               mem_widx  = link_idx(region_start_ff);
               mem_wdata = head_ff[HI_W'(left_q - 17'd1)];
            end
            region_start_in = region_end_ff;
            get_in   = GET_W'({total_ff, 1'b0}) + GET_W'(heap_round);
            state_in = S_GROW;
         end
         S_GROW: begin
            if (grow_end <= 22'(ARENA_BYTES)) begin
               region_start_in = backing_ff;
               region_end_in   = grow_end[ADDR_W-1:0];
               backing_in      = grow_end[ADDR_W-1:0];
               heap_in         = heap_ff + get_ff[ADDR_W-1:0];
               state_in        = S_CHECK;
            end else begin
               search_in = CLS_W'(cls_ff);
               state_in  = S_SEARCH;
            end
         end
         S_SEARCH: begin
            // walk the larger classes, one per cycle
            if (search_ff >= CLS_W'(NUM_CLASSES) || class_bytes > 17'(max_size_ff)) begin
               res_status_in = ST_NO_MEMORY;
               state_in      = S_DONE;
            end else if (head_ff[search_ff[HI_W-1:0]] != NIL_LINK) begin
               tgt_in   = search_ff[HI_W-1:0];
               hit_in   = 1'b0;
               first_in = head_ff[search_ff[HI_W-1:0]];
               mem_re   = 1'b1;
               mem_ridx = link_idx(head_ff[search_ff[HI_W-1:0]]);
               state_in = S_POP;
            end else begin
               search_in = search_ff + CLS_W'(1);
            end
         end
         S_CHECK: begin
            if (residue < 17'(sz_ff)) begin
               res_status_in = ST_NO_MEMORY;
               state_in      = S_DONE;
            end else if (TOTAL_W'(residue) >= total_ff) begin
               state_in = S_SPAN;
            end else begin
               rem_in   = residue;
               q_in     = '0;
               step_in  = 3'(CNT_W - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            if (DIV_W'(rem_ff) >= divisor) begin
               rem_in        = rem_ff - divisor[ADDR_W-1:0];
               q_in[step_ff] = 1'b1;
            end
            step_in = step_ff - 3'd1;
            if (step_ff == '0) begin
               n_in     = q_in;
               state_in = S_SPAN;
            end
         end
         S_SPAN: begin
            total_in = TOTAL_W'(sz_ff) * TOTAL_W'(n_ff);
            state_in = S_SETUP;
         end
         S_SETUP: begin
            first_in        = region_start_ff;
            region_start_in = setup_sum[ADDR_W-1:0];
            cursor_in       = ADDR_W'(setup_sum - TOTAL_W'(sz_ff));
            state_in        = S_LINK;
         end
         S_LINK: begin
            // link the carved objects from the highest address down
            if (n_ff > CNT_W'(1)) begin
               hd_we     = 1'b1;
               hd_idx    = cls_ff;
               hd_val    = cursor_ff;
               mem_we    = 1'b1;
               mem_widx  = link_idx(cursor_ff);
               mem_wdata = head_ff[cls_ff];
               cursor_in = cursor_ff - 17'(sz_ff);
               n_in      = n_ff - CNT_W'(1);
            end else begin
               res_addr_in   = first_ff[15:0];
               res_status_in = ST_OK;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = (res_status_ff == ST_OK) ? res_addr_ff : '0;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         region_start_ff <= '0;
         region_end_ff   <= '0;
         heap_ff         <= '0;
         backing_ff      <= '0;
         align_shift_ff  <= 3'd3;
         max_size_ff     <= 11'd128;
         per_refill_ff   <= 7'd20;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         region_start_ff <= region_start_in;
         region_end_ff   <= region_end_in;
         heap_ff         <= heap_in;
         backing_ff      <= backing_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_ALIGN_SHIFT: align_shift_ff <= csr_write_data[2:0];
               CSR_MAX_SIZE:    max_size_ff    <= csr_write_data;
               CSR_PER_REFILL:  per_refill_ff  <= csr_write_data[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i] <= NIL_LINK;
         end
      end else if (hd_we) begin
         head_ff[hd_idx] <= hd_val;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      cls_ff        <= cls_in;
      tgt_ff        <= tgt_in;
      search_ff     <= search_in;
      hit_ff        <= hit_in;
      sz_ff         <= sz_in;
      total_ff      <= total_in;
      get_ff        <= get_in;
      n_ff          <= n_in;
      q_ff          <= q_in;
      step_ff       <= step_in;
      rem_ff        <= rem_in;
      first_ff      <= first_in;
      cursor_ff     <= cursor_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_widx] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= link_mem[mem_ridx];
      end
   end

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the segregated free-list allocator.
`timescale 1ns / 1ps

module tb_top;
   import sfa_pkg::*;

   localparam int          LINK_DEPTH  = 8192;
   localparam int          CLASS_COUNT = 16;
   localparam int unsigned ADDR_MASK   = 32'h1FFFF;
   localparam int          CYCLE_LIMIT = 2000000;
   localparam int          PHASE_ITEMS = 190;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_ALLOC;
   logic [15:0] req_size_bytes = '0;
   logic [15:0] req_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_result_address;
   logic [1:0]  rsp_status;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = CSR_ALIGN_SHIFT;
   logic [10:0] csr_write_data = '0;

   segregated_freelist_allocator dut (.*);

   always #6 clock = ~clock;

   typedef struct {
      logic [15:0] address;
      logic [1:0]  status;
   } grant_type;

   typedef struct {
      logic [15:0] address;
      logic [15:0] size;
   } live_block_type;

   typedef struct {
      logic        operation;
      logic [15:0] size;
      logic [15:0] address;
      bit          typed;      // expectation written in the row
      logic [15:0] grant_address;
      logic [1:0]  grant_status;
   } stim_row_type;

   grant_type      pending_grants[$];   // responses still owed by the block
   live_block_type live_blocks[$];      // objects handed out and not yet returned

   int   error_count = 0;
   int   cycle_count = 0;
   int   requests_sent = 0;
   int   grants_checked = 0;
   int   no_memory_seen = 0;
   bit   quiet = 1'b0;               // suppress idling on both sides

   // Shadow allocator state.
   logic [16:0] free_heads[CLASS_COUNT];
   logic [16:0] next_links[LINK_DEPTH];
   int unsigned carve_start, carve_end, heap_total, backing_top;
   int unsigned cfg_shift, cfg_max_size, cfg_per_refill;

   // ---------------------------------------------------------------
   // Shadow allocator
   // ---------------------------------------------------------------
   function automatic int unsigned align_bytes();
      int unsigned a;
      a = 1 << (cfg_shift & 7);
      return (a < 8) ? 8 : a;
   endfunction

   function automatic void push_free(int unsigned cls, int unsigned addr);
      next_links[(addr / 8) % LINK_DEPTH] = free_heads[cls];
      free_heads[cls] = 17'(addr & ADDR_MASK);
   endfunction

   function automatic int unsigned pop_free(int unsigned cls);
      int unsigned addr;
      addr = 32'(free_heads[cls]);
      free_heads[cls] = next_links[(addr / 8) % LINK_DEPTH];
      return addr;
   endfunction

   function automatic void allocate_object(input int unsigned size,
                                           output int unsigned addr,
                                           output logic [1:0] st);
      int unsigned a, cls, sz, n, residue, grab, first, i, k;
      bit found;
      a = align_bytes();
      addr = 0;
      st = ST_OK;
      if (size == 0) begin
         st = ST_ZERO_SIZE;
         return;
      end
      if (size > cfg_max_size) begin
         st = ST_TOO_LARGE;
         return;
      end
      cls = (size + a - 1) / a - 1;
      if (cls >= CLASS_COUNT) begin
         st = ST_TOO_LARGE;
         return;
      end
      if (free_heads[cls] != NIL_LINK) begin
         addr = pop_free(cls) & 16'hFFFF;
         return;
      end
      sz = (cls + 1) * a;
      n = (cfg_per_refill != 0) ? cfg_per_refill : 1;
      residue = (carve_end >= carve_start) ? carve_end - carve_start : 0;
      if (residue < sz) begin
         grab = 2 * sz * n + (((heap_total >> 4) + a - 1) / a) * a;
         // hand the leftover of the old region to the list of its own size
         if (residue >= a && residue / a - 1 < CLASS_COUNT)
            push_free(residue / a - 1, carve_start);
         carve_start = carve_end;
         if (backing_top + grab <= 65536) begin
            carve_start = backing_top;
            carve_end = backing_top + grab;
            backing_top += grab;
            heap_total += grab;
         end else begin
            // backing store full: borrow one larger free object as the region
            found = 1'b0;
            for (i = sz; i <= cfg_max_size; i += a) begin
               k = i / a - 1;
               if (k >= CLASS_COUNT) break;
               if (free_heads[k] != NIL_LINK) begin
                  first = pop_free(k);
                  carve_start = first;
                  carve_end = (first + i) & ADDR_MASK;
                  found = 1'b1;
                  break;
               end
            end
            if (!found) begin
               st = ST_NO_MEMORY;
               return;
            end
         end
         residue = (carve_end >= carve_start) ? carve_end - carve_start : 0;
         if (residue < sz) begin
            st = ST_NO_MEMORY;
            return;
         end
      end
      if (residue < sz * n) n = residue / sz;
      first = carve_start;
      carve_start = (carve_start + sz * n) & ADDR_MASK;
      for (i = n; i > 1; i--)
         push_free(cls, (first + sz * (i - 1)) & ADDR_MASK);
      addr = first & 16'hFFFF;
   endfunction

   function automatic logic [1:0] release_object(int unsigned size, int unsigned addr);
      int unsigned a, cls;
      a = align_bytes();
      if (size == 0) return ST_ZERO_SIZE;
      if (size > cfg_max_size) return ST_TOO_LARGE;
      cls = (size + a - 1) / a - 1;
      if (cls >= CLASS_COUNT) return ST_TOO_LARGE;
      push_free(cls, addr);
      return ST_OK;
   endfunction

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------
   function automatic bit idle_now();
      return !quiet && ($urandom_range(99) < 26);
   endfunction

   // Offer one request, hold it until taken, then queue the owed response.
   task automatic send_request(input stim_row_type row);
      grant_type   g;
      int unsigned addr;
      req_valid      <= 1'b1;
      req_operation  <= row.operation;
      req_size_bytes <= row.size;
      req_address    <= row.address;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      if (row.operation == OP_ALLOC) begin
         allocate_object(32'(row.size), addr, g.status);
         g.address = addr[15:0];
         if (g.status == ST_OK) live_blocks.push_back('{g.address, row.size});
         if (g.status == ST_NO_MEMORY) no_memory_seen++;
      end else begin
         g.status = release_object(32'(row.size), 32'(row.address));
         g.address = '0;
      end
      if (row.typed) begin
         g.address = row.grant_address;
         g.status  = row.grant_status;
      end
      pending_grants.push_back(g);
      // insert a random gap before the next request
      if (idle_now()) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Drain all owed responses, then write one register.
   task automatic write_register(input logic [1:0] idx, input int unsigned value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value[10:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_ALIGN_SHIFT: cfg_shift      = value & 7;
         CSR_MAX_SIZE:    cfg_max_size   = value & 11'h7FF;
         CSR_PER_REFILL:  cfg_per_refill = value & 7'h7F;
         default: ;
      endcase
   endtask

   // Build one random request: mostly allocate/free traffic, some noise.
   function automatic stim_row_type random_request();
      stim_row_type row;
      int unsigned  pick, top, slot;
      row = '{OP_ALLOC, 16'd0, 16'd0, 1'b0, 16'd0, ST_OK};
      pick = $urandom_range(99);
      top = align_bytes() * CLASS_COUNT;
      if (top > cfg_max_size) top = cfg_max_size;
      if (pick < 50) begin
         row.size = 16'($urandom_range(1, top));
         row.address = 16'($urandom);
      end else if (pick < 88 && live_blocks.size() != 0) begin
         slot = $urandom_range(live_blocks.size() - 1);
         row.operation = OP_FREE;
         row.size = live_blocks[slot].size;
         row.address = live_blocks[slot].address;
         live_blocks.delete(slot);
      end else begin
         row.operation = 1'($urandom_range(1));
         case ($urandom_range(3))
            0:       row.size = 16'd0;
            1:       row.size = 16'($urandom);
            2:       row.size = 16'(cfg_max_size + $urandom_range(1, 8));
            default: row.size = 16'($urandom_range(1, top));
         endcase
         row.address = 16'($urandom);
      end
      return row;
   endfunction

   // ---------------------------------------------------------------
   // Response side: random stall and compare
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_stall <= idle_now();
   end

   always @(posedge clock) begin
      grant_type g;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            $error("unexpected response: result_address=%h status=%0d",
                   rsp_result_address, rsp_status);
            error_count++;
         end else begin
            g = pending_grants.pop_front();
            grants_checked++;
            if (rsp_result_address !== g.address) begin
               $error("result_address: expected %h, got %h", g.address, rsp_result_address);
               error_count++;
            end
            if (rsp_status !== g.status) begin
               $error("status: expected %0d, got %0d", g.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses owed",
                  cycle_count, pending_grants.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   // Directed rows at reset settings (alignment 8, max 128, 20 per refill).
   stim_row_type directed_rows[19] = '{
      '{OP_ALLOC, 16'd8,     16'd0,     1'b1, 16'd0, ST_OK},        // first refill
      '{OP_ALLOC, 16'd0,     16'd0,     1'b1, 16'd0, ST_ZERO_SIZE},
      '{OP_ALLOC, 16'd129,   16'd0,     1'b1, 16'd0, ST_TOO_LARGE},
      '{OP_ALLOC, 16'hFFFF,  16'hFFFF,  1'b1, 16'd0, ST_TOO_LARGE},
      '{OP_FREE,  16'd0,     16'd64,    1'b1, 16'd0, ST_ZERO_SIZE},
      '{OP_FREE,  16'd200,   16'd64,    1'b1, 16'd0, ST_TOO_LARGE},
      '{OP_FREE,  16'hFFFF,  16'h0000,  1'b1, 16'd0, ST_TOO_LARGE},
      '{OP_ALLOC, 16'd8,     16'd0,     1'b1, 16'd8, ST_OK},        // pop head
      '{OP_ALLOC, 16'd1,     16'd0,     1'b0, 16'd0, ST_OK},
      '{OP_ALLOC, 16'd128,   16'd0,     1'b0, 16'd0, ST_OK},        // largest class
      '{OP_FREE,  16'd128,   16'hFFFF,  1'b1, 16'd0, ST_OK},        // odd address
      '{OP_ALLOC, 16'd121,   16'd0,     1'b1, 16'hFFFF, ST_OK},     // gets it back
      '{OP_FREE,  16'd8,     16'd0,     1'b1, 16'd0, ST_OK},
      '{OP_ALLOC, 16'd7,     16'd0,     1'b1, 16'd0, ST_OK},
      '{OP_ALLOC, 16'd64,    16'h5A5A,  1'b0, 16'd0, ST_OK},
      '{OP_FREE,  16'd64,    16'hA5A0,  1'b1, 16'd0, ST_OK},
      '{OP_ALLOC, 16'd57,    16'd0,     1'b1, 16'hA5A0, ST_OK},
      '{OP_ALLOC, 16'd100,   16'd0,     1'b0, 16'd0, ST_OK},
      '{OP_ALLOC, 16'd9,     16'd0,     1'b0, 16'd0, ST_OK}
   };

   // Settings per random phase: alignment shift, max size, objects per refill.
   int unsigned phase_cfg[6][3] = '{
      '{3, 128, 20}, '{0, 1, 1}, '{6, 1024, 64},
      '{2, 64, 0},   '{4, 300, 7}, '{5, 1000, 33}
   };

   initial begin
      int wait_cycles;
      for (int i = 0; i < CLASS_COUNT; i++) free_heads[i] = NIL_LINK;
      for (int i = 0; i < LINK_DEPTH; i++) next_links[i] = '0;
      carve_start = 0;
      carve_end = 0;
      heap_total = 0;
      backing_top = 0;
      cfg_shift = 3;
      cfg_max_size = 128;
      cfg_per_refill = 20;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      for (int p = 0; p < 6; p++) begin
         write_register(CSR_ALIGN_SHIFT, phase_cfg[p][0]);
         write_register(CSR_MAX_SIZE,    phase_cfg[p][1]);
         write_register(CSR_PER_REFILL,  phase_cfg[p][2]);
         // run phase two with no idling on either side
         quiet = (p == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // in phase four, hold off once mid-phase until the block has drained
            if (p == 3 && n == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending_grants.size() != 0) @(posedge clock);
            end
            send_request(random_request());
         end
         quiet = 1'b0;
      end

      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_grants.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (pending_grants.size() != 0) begin
         $error("%0d responses never arrived", pending_grants.size());
         error_count++;
      end

      $display("covered %0d requests over 6 register settings, %0d responses checked",
               requests_sent, grants_checked);
      $display("out-of-memory answers predicted: %0d, %0d mismatches",
               no_memory_seen, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/sfa_pkg.sv
design/segregated_freelist_allocator.sv
verif/tb_top.sv
